[src/sha256_byte_stream_hash_assert.svh]
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher: assertion macros
// Clocked, reset-qualified property shorthand used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SHA256_BYTE_STREAM_HASH_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASH_ASSERT_SVH

// Plain clocked property, disabled while reset is asserted.
`define SHABS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication checked in the next cycle, disabled while reset is asserted.
`define SHABS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/shabs_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher: package
// Transaction types, round constants and the SHA-256 mixing functions.
// ----------------------------------------------------------------------------
package shabs_pkg;

  localparam int unsigned WordW      = 32;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned HashWords  = 8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef logic [31:0] word_t;

  localparam word_t InitHash [HashWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundConst [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Control states, one-hot
  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StPrime = 6'b000010,
    StRound = 6'b000100,
    StFinal = 6'b001000,
    StPad   = 6'b010000,
    StOut   = 6'b100000
  } state_e;

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t big_sigma0(word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sigma0(word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

[src/shabs_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module shabs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/sha256_byte_stream_hash.sv]
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Packs message bytes into a block buffer and compresses each full block.
// ----------------------------------------------------------------------------
// One message byte is taken per transaction and packed big-endian into a
// 16-word block buffer RAM. The 64th byte of a block starts a compression
// (RAM prime, one round per cycle, hash update), during which input is
// stalled. The transaction that ends the message adds a padding setup step
// and one compression, or two when more than 55 bytes of the last block are
// filled; the eight digest words are then presented one per cycle while the
// output is not stalled, word 0 first, and the hasher returns to its initial
// state for the next message.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hash (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  shabs_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output shabs_pkg::out_item_t out_data_o
);

  shabs_pkg::state_e state_q, state_d;

  shabs_pkg::word_t hash_q [shabs_pkg::HashWords];
  shabs_pkg::word_t hash_d [shabs_pkg::HashWords];
  shabs_pkg::word_t var_q  [shabs_pkg::HashWords];
  shabs_pkg::word_t var_d  [shabs_pkg::HashWords];
  shabs_pkg::word_t sched_q [shabs_pkg::BlockWords];
  shabs_pkg::word_t sched_d [shabs_pkg::BlockWords];

  logic [63:0] cnt_q, cnt_d;
  logic [31:0] wacc_q, wacc_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [4:0]  nw_q, nw_d;
  logic [31:0] tail_q, tail_d;
  logic [3:0]  tail_idx_q, tail_idx_d;
  logic        tail_v_q, tail_v_d;
  logic        len_q, len_d;
  logic        pad2_q, pad2_d;
  logic        end_q, end_d;
  logic        padded_q, padded_d;
  logic [2:0]  oidx_q, oidx_d;

  logic        in_acc;
  logic [5:0]  pos_in;
  logic [31:0] wnew;
  logic        ram_we;
  logic [3:0]  ram_raddr;
  logic [31:0] ram_rdata;
  logic [63:0] bits;
  logic [31:0] src_w, w, t1, t2;
  logic [5:0]  pad_pos;

  assign in_acc = in_valid_i && (state_q == shabs_pkg::StIdle);
  assign pos_in = cnt_q[5:0];
  assign wnew   = wacc_q | ({in_data_i.data_byte, 24'h0} >> {pos_in[1:0], 3'b000});
  assign ram_we = in_acc && in_data_i.has_byte && (pos_in[1:0] == 2'd3);
  assign bits   = {cnt_q[60:0], 3'b000};
  assign pad_pos = cnt_q[5:0];

  // Read one word ahead of the round that uses it
  always_comb begin
    if (state_q == shabs_pkg::StPrime) begin
      ram_raddr = 4'd0;
    end else begin
      ram_raddr = rnd_q[3:0] + 4'd1;
    end
  end

  shabs_ram #(
    .Width (32),
    .Depth (shabs_pkg::BlockWords)
  ) u_block_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos_in[5:2]),
    .wdata_i (wnew),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Select the block word: buffered words, then padding tail, zeros, length
  always_comb begin
    if ({1'b0, rnd_q[3:0]} < nw_q) begin
      src_w = ram_rdata;
    end else if (tail_v_q && (rnd_q[3:0] == tail_idx_q)) begin
      src_w = tail_q;
    end else if (len_q && (rnd_q[3:0] == 4'd14)) begin
      src_w = bits[63:32];
    end else if (len_q && (rnd_q[3:0] == 4'd15)) begin
      src_w = bits[31:0];
    end else begin
      src_w = '0;
    end
  end

  // Message schedule word and round sums
  always_comb begin
    if (rnd_q < 6'd16) begin
      w = src_w;
    end else begin
      w = shabs_pkg::small_sigma1(sched_q[14]) + sched_q[9]
        + shabs_pkg::small_sigma0(sched_q[1]) + sched_q[0];
    end
    t1 = var_q[7] + shabs_pkg::big_sigma1(var_q[4])
       + ((var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]))
       + shabs_pkg::RoundConst[rnd_q] + w;
    t2 = shabs_pkg::big_sigma0(var_q[0])
       + ((var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]));
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    hash_d     = hash_q;
    var_d      = var_q;
    sched_d    = sched_q;
    cnt_d      = cnt_q;
    wacc_d     = wacc_q;
    rnd_d      = rnd_q;
    nw_d       = nw_q;
    tail_d     = tail_q;
    tail_idx_d = tail_idx_q;
    tail_v_d   = tail_v_q;
    len_d      = len_q;
    pad2_d     = pad2_q;
    end_d      = end_q;
    padded_d   = padded_q;
    oidx_d     = oidx_q;

    case (state_q)
      shabs_pkg::StIdle: begin
        if (in_acc) begin
          end_d = in_data_i.end_of_message;
          if (in_data_i.has_byte) begin
            cnt_d  = cnt_q + 64'd1;
            wacc_d = (pos_in[1:0] == 2'd3) ? '0 : wnew;
          end
          if (in_data_i.has_byte && (pos_in == 6'd63)) begin
            // full block: compress straight from the buffer
            nw_d     = 5'd16;
            tail_v_d = 1'b0;
            len_d    = 1'b0;
            state_d  = shabs_pkg::StPrime;
          end else if (in_data_i.end_of_message) begin
            state_d = shabs_pkg::StPad;
          end
        end
      end
      shabs_pkg::StPad: begin
        // place the pad byte behind the buffered bytes
        padded_d   = 1'b1;
        nw_d       = {1'b0, pad_pos[5:2]};
        tail_d     = wacc_q | ({8'h80, 24'h0} >> {pad_pos[1:0], 3'b000});
        tail_idx_d = pad_pos[5:2];
        tail_v_d   = 1'b1;
        if (pad_pos > 6'd55) begin
          len_d  = 1'b0;
          pad2_d = 1'b1;
        end else begin
          len_d  = 1'b1;
        end
        state_d = shabs_pkg::StPrime;
      end
      shabs_pkg::StPrime: begin
        var_d   = hash_q;
        rnd_d   = '0;
        state_d = shabs_pkg::StRound;
      end
      shabs_pkg::StRound: begin
        for (int i = 0; i < 15; i++) begin
          sched_d[i] = sched_q[i+1];
        end
        sched_d[15] = w;
        var_d[7] = var_q[6];
        var_d[6] = var_q[5];
        var_d[5] = var_q[4];
        var_d[4] = var_q[3] + t1;
        var_d[3] = var_q[2];
        var_d[2] = var_q[1];
        var_d[1] = var_q[0];
        var_d[0] = t1 + t2;
        rnd_d    = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = shabs_pkg::StFinal;
        end
      end
      shabs_pkg::StFinal: begin
        for (int i = 0; i < shabs_pkg::HashWords; i++) begin
          hash_d[i] = hash_q[i] + var_q[i];
        end
        if (pad2_q) begin
          // second padding block: zeros and the length
          pad2_d   = 1'b0;
          nw_d     = '0;
          tail_v_d = 1'b0;
          len_d    = 1'b1;
          state_d  = shabs_pkg::StPrime;
        end else if (end_q && !padded_q) begin
          state_d = shabs_pkg::StPad;
        end else if (end_q) begin
          oidx_d  = '0;
          state_d = shabs_pkg::StOut;
        end else begin
          state_d = shabs_pkg::StIdle;
        end
      end
      shabs_pkg::StOut: begin
        if (!out_stall_i) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            // digest delivered: restart for the next message
            hash_d   = shabs_pkg::InitHash;
            cnt_d    = '0;
            wacc_d   = '0;
            end_d    = 1'b0;
            padded_d = 1'b0;
            state_d  = shabs_pkg::StIdle;
          end
        end
      end
      default: begin
        state_d = shabs_pkg::StIdle;
      end
    endcase
  end

  // Control and hash state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= shabs_pkg::StIdle;
      hash_q   <= shabs_pkg::InitHash;
      cnt_q    <= '0;
      wacc_q   <= '0;
      rnd_q    <= '0;
      pad2_q   <= 1'b0;
      end_q    <= 1'b0;
      padded_q <= 1'b0;
      oidx_q   <= '0;
    end else begin
      state_q  <= state_d;
      hash_q   <= hash_d;
      cnt_q    <= cnt_d;
      wacc_q   <= wacc_d;
      rnd_q    <= rnd_d;
      pad2_q   <= pad2_d;
      end_q    <= end_d;
      padded_q <= padded_d;
      oidx_q   <= oidx_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    var_q      <= var_d;
    sched_q    <= sched_d;
    nw_q       <= nw_d;
    tail_q     <= tail_d;
    tail_idx_q <= tail_idx_d;
    tail_v_q   <= tail_v_d;
    len_q      <= len_d;
  end

  assign in_stall_o              = (state_q != shabs_pkg::StIdle);
  assign out_valid_o             = (state_q == shabs_pkg::StOut);
  assign out_data_o.digest_word  = hash_q[oidx_q];
  assign out_data_o.word_index   = oidx_q;
  assign out_data_o.last_word    = (oidx_q == 3'd7);

endmodule

[src/shabs_checker.sv]
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher: port checker
// Watches the top-level ports for digest sequencing and flow control.
// ----------------------------------------------------------------------------
`include "sha256_byte_stream_hash_assert.svh"

module shabs_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input shabs_pkg::in_item_t  in_data_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input shabs_pkg::out_item_t out_data_o
);

  // A stalled digest word stays offered
  `SHABS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled output changed")

  // No input transaction while the digest is read out
  `SHABS_ASSERT(a_in_blocked, out_valid_o |-> in_stall_o, "input taken during digest output")

  // Last-word flag marks index seven
  `SHABS_ASSERT(a_last_flag, out_valid_o |-> (out_data_o.last_word == (out_data_o.word_index == 3'd7)), "last_word mismatch")

  // Digest words follow in order
  `SHABS_ASSERT_NEXT(a_idx_step, out_valid_o && !out_stall_i && !out_data_o.last_word, out_valid_o && (out_data_o.word_index == $past(out_data_o.word_index) + 3'd1), "word index skipped")

  // Output ends after the last word
  `SHABS_ASSERT_NEXT(a_out_end, out_valid_o && !out_stall_i && out_data_o.last_word, !out_valid_o, "output continued past last word")

endmodule

bind sha256_byte_stream_hash shabs_checker u_shabs_checker (.*);
